### rtl/pwf_pkg.sv
// ----------------------------------------------------------------------------
// pwf_pkg: shared types and constants
// fixed-point widths, register indexes and saturation helper for the
// particle wall friction pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package pwf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VW         = 32;               // velocity / position width
    localparam int TS_W       = 17;               // time step width
    localparam int MU_W       = 21;               // friction width
    localparam int LIM_W      = MU_W + VW;        // friction * |vn|
    localparam int SQ_W       = 2 * VW;           // sum of squares
    localparam int Q_W        = FRAC_BITS;        // slide quotient width
    localparam int PROD_W     = VW + Q_W + 2;     // tangent * scale
    localparam int FPROD_W    = VW + TS_W + 1;    // time step * velocity
    localparam int IDX_W      = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int IN_W       = 6 * VW;
    localparam int OUT_W      = 104;              // 3 * VW + 3 padded to bytes

    localparam logic signed [2*VW-1:0] WIDE_MAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam logic signed [2*VW-1:0] WIDE_MIN = -(64'sd1 <<< (VW - 1));

    typedef enum logic [IDX_W-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5,
        REG_TIME_STEP = 3'd6,
        REG_FRICTION  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][VW-1:0] box_min;
        logic [2:0][VW-1:0] box_max;
        logic [TS_W-1:0]    time_step;
        logic [MU_W-1:0]    friction;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [VW-1:0] vel_x;
        logic signed [VW-1:0] vel_y;
        logic signed [VW-1:0] vel_z;
        logic [2:0]           hit_mask;
    } item_t;

    // velocity rotated so that va is the wall normal
    typedef struct packed {
        logic                 valid;
        logic                 en;
        logic [2:0]           mask;
        logic signed [VW-1:0] va;
        logic signed [VW-1:0] vb;
        logic signed [VW-1:0] vc;
    } wall_bus_t;

    function automatic logic signed [VW-1:0] sat_vel(input logic signed [2*VW-1:0] x);
        logic signed [VW-1:0] r;
        if (x > WIDE_MAX) begin
            r = WIDE_MAX[VW-1:0];
        end else if (x < WIDE_MIN) begin
            r = WIDE_MIN[VW-1:0];
        end else begin
            r = x[VW-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/pwf_front.sv
// ----------------------------------------------------------------------------
// pwf_front: position prediction and wall classification
// one register stage for the time step products, then saturating add and
// box compare straight into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module pwf_front
    import pwf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output item_t                 push_item
);

    logic                               f_valid_reg, f_valid_next;
    logic signed [2:0][VW-1:0]          pos_reg;
    logic signed [2:0][VW-1:0]          vel_reg;
    logic signed [2:0][FPROD_W-1:0]     prod_reg;
    logic                               accept;

    assign s_tready   = !f_valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = f_valid_reg;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = 1'b1;
        end else if (push_ready) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < 3; k++) begin
                pos_reg[k]  <= s_tdata[k*VW +: VW];
                vel_reg[k]  <= s_tdata[(3+k)*VW +: VW];
                prod_reg[k] <= $signed({1'b0, cfg.time_step})
                               * $signed(s_tdata[(3+k)*VW +: VW]);
            end
        end
    end

    always_comb begin
        logic signed [VW-1:0] pred;
        logic [2:0]           hit;
        for (int k = 0; k < 3; k++) begin
            // element selects of a packed array are unsigned, so re-sign them
            pred = sat_vel((2*VW)'($signed(pos_reg[k]))
                           + (2*VW)'($signed(prod_reg[k]) >>> FRAC_BITS));
            hit[k] = (pred > $signed(cfg.box_max[k])) || (pred < $signed(cfg.box_min[k]));
        end
        push_item.vel_x    = vel_reg[0];
        push_item.vel_y    = vel_reg[1];
        push_item.vel_z    = vel_reg[2];
        push_item.hit_mask = hit;
    end

endmodule

`default_nettype wire

### rtl/pwf_fifo.sv
// ----------------------------------------------------------------------------
// pwf_fifo: short queue between front and back
// register file queue, head shown combinationally
// ----------------------------------------------------------------------------
`default_nettype none

module pwf_fifo
    import pwf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire item_t     push_item,
    input  wire logic      pop,
    output logic           full,
    output logic           empty,
    output logic [FIFO_AW:0] count,
    output item_t          head
);

    item_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/pwf_wall.sv
// ----------------------------------------------------------------------------
// pwf_wall: friction response of one wall
// squares and friction limit, pipelined integer square root one bit a
// stage, stick test, restoring divide one quotient bit a stage, rescale
// ----------------------------------------------------------------------------
`default_nettype none

module pwf_wall
    import pwf_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            adv,
    input  wire logic [MU_W-1:0] friction,
    input  wire wall_bus_t       in_bus,
    output wall_bus_t            out_bus
);

    localparam int S_SUM   = 1;
    localparam int S_ROOT0 = 2;
    localparam int S_CMP   = S_ROOT0 + VW;
    localparam int S_DIV0  = S_CMP + 1;
    localparam int S_MUL   = S_DIV0 + Q_W;
    localparam int S_OUT   = S_MUL + 1;
    localparam int NST     = S_OUT + 1;

    typedef struct packed {
        logic                     en;
        logic [2:0]               mask;
        logic signed [VW-1:0]     va;
        logic signed [VW-1:0]     vb;
        logic signed [VW-1:0]     vc;
        logic [SQ_W-1:0]          sq_b;
        logic [SQ_W-1:0]          sq_c;
        logic [SQ_W-1:0]          n;
        logic [SQ_W-1:0]          root;
        logic [LIM_W-1:0]         lim;
        logic [LIM_W-1:0]         rem;
        logic [VW-1:0]            vt;
        logic                     stick;
        logic [Q_W-1:0]           q;
        logic signed [PROD_W-1:0] pb;
        logic signed [PROD_W-1:0] pc;
    } wstage_t;

    wstage_t          st_reg  [NST];
    wstage_t          st_next [NST];
    logic [NST-1:0]   valid_reg;

    always_comb begin
        logic [VW-1:0]      ma, mb, mc;
        logic [SQ_W-1:0]    trial;
        logic [LIM_W-1:0]   dv;
        logic [Q_W:0]       s;
        for (int i = 1; i < NST; i++) begin
            st_next[i] = st_reg[i-1];
        end

        // squares of the tangential parts and the friction limit
        ma = in_bus.va[VW-1] ? (~in_bus.va + 1'b1) : in_bus.va;
        mb = in_bus.vb[VW-1] ? (~in_bus.vb + 1'b1) : in_bus.vb;
        mc = in_bus.vc[VW-1] ? (~in_bus.vc + 1'b1) : in_bus.vc;
        st_next[0]      = st_reg[0];
        st_next[0].en   = in_bus.en;
        st_next[0].mask = in_bus.mask;
        st_next[0].va   = in_bus.en ? '0 : in_bus.va;
        st_next[0].vb   = in_bus.vb;
        st_next[0].vc   = in_bus.vc;
        st_next[0].sq_b = SQ_W'(mb) * SQ_W'(mb);
        st_next[0].sq_c = SQ_W'(mc) * SQ_W'(mc);
        st_next[0].lim  = LIM_W'(friction) * LIM_W'(ma);

        st_next[S_SUM].n    = st_reg[S_SUM-1].sq_b + st_reg[S_SUM-1].sq_c;
        st_next[S_SUM].root = '0;

        // square root, one result bit a stage
        for (int j = 0; j < VW; j++) begin
            trial = st_reg[S_ROOT0+j-1].root + (SQ_W'(1) << (2*(VW-1-j)));
            if (st_reg[S_ROOT0+j-1].n >= trial) begin
                st_next[S_ROOT0+j].n    = st_reg[S_ROOT0+j-1].n - trial;
                st_next[S_ROOT0+j].root = (st_reg[S_ROOT0+j-1].root >> 1)
                                          + (SQ_W'(1) << (2*(VW-1-j)));
            end else begin
                st_next[S_ROOT0+j].root = st_reg[S_ROOT0+j-1].root >> 1;
            end
        end

        // stick test
        st_next[S_CMP].vt    = st_reg[S_CMP-1].root[VW-1:0];
        st_next[S_CMP].stick = ((LIM_W+1)'({st_reg[S_CMP-1].root[VW-1:0], Q_W'(0)})
                                <= (LIM_W+1)'(st_reg[S_CMP-1].lim));
        st_next[S_CMP].rem   = st_reg[S_CMP-1].lim;
        st_next[S_CMP].q     = '0;

        // restoring divide, quotient below one when sliding
        for (int j = 0; j < Q_W; j++) begin
            dv = LIM_W'(st_reg[S_DIV0+j-1].vt) << (Q_W-1-j);
            if (st_reg[S_DIV0+j-1].rem >= dv) begin
                st_next[S_DIV0+j].rem          = st_reg[S_DIV0+j-1].rem - dv;
                st_next[S_DIV0+j].q[Q_W-1-j]   = 1'b1;
            end
        end

        // tangential rescale
        s = {1'b1, Q_W'(0)} - {1'b0, st_reg[S_MUL-1].q};
        st_next[S_MUL].pb = st_reg[S_MUL-1].vb * $signed({1'b0, s});
        st_next[S_MUL].pc = st_reg[S_MUL-1].vc * $signed({1'b0, s});

        if (st_reg[S_OUT-1].en) begin
            if (st_reg[S_OUT-1].stick) begin
                st_next[S_OUT].vb = '0;
                st_next[S_OUT].vc = '0;
            end else begin
                st_next[S_OUT].vb = sat_vel((2*VW)'(st_reg[S_OUT-1].pb >>> FRAC_BITS));
                st_next[S_OUT].vc = sat_vel((2*VW)'(st_reg[S_OUT-1].pc >>> FRAC_BITS));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NST-2:0], in_bus.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NST; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_bus.valid = valid_reg[NST-1];
    assign out_bus.en    = st_reg[NST-1].en;
    assign out_bus.mask  = st_reg[NST-1].mask;
    assign out_bus.va    = st_reg[NST-1].va;
    assign out_bus.vb    = st_reg[NST-1].vb;
    assign out_bus.vc    = st_reg[NST-1].vc;

endmodule

`default_nettype wire

### rtl/particle_wall_friction.sv
// ----------------------------------------------------------------------------
// particle_wall_friction: Coulomb friction of a particle against box walls
// predicts position, flags the x, y and z walls that are hit and applies
// friction wall by wall in three chained pipelines
// ----------------------------------------------------------------------------
// pipeline: one front register stage, the queue, then 53 stages per wall for 3 walls;
//   results wait in the last wall stage while the result side stalls
// throughput: one item per cycle unless the result side stalls; the square root and divide
//   units are fully pipelined, one bit per stage, so each wall takes a new item every cycle adv is high
// reset: synchronous active-low aresetn empties pipeline and queue and loads
//   the default box, time step and friction; no clearing pass
`default_nettype none

module particle_wall_friction
    import pwf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [VW-1:0]     cfg_data,
    // particle input
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    // result output
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata    // new_vel_x, new_vel_y, new_vel_z, hit_mask, pad
);

    cfg_t             cfg_reg;
    logic             push_valid, push_ready;
    item_t            push_item, head;
    logic             fifo_full, fifo_empty, pop, adv;
    logic [FIFO_AW:0] fifo_count;
    wall_bus_t        w0_in, w0_out, w1_in, w1_out, w2_in, w2_out;

    // configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.box_min   <= '0;
            cfg_reg.box_max   <= {3{VW'(32'd65536)}};
            cfg_reg.time_step <= TS_W'(17'd655);
            cfg_reg.friction  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_BOX_MIN_X: cfg_reg.box_min[0] <= cfg_data;
                REG_BOX_MIN_Y: cfg_reg.box_min[1] <= cfg_data;
                REG_BOX_MIN_Z: cfg_reg.box_min[2] <= cfg_data;
                REG_BOX_MAX_X: cfg_reg.box_max[0] <= cfg_data;
                REG_BOX_MAX_Y: cfg_reg.box_max[1] <= cfg_data;
                REG_BOX_MAX_Z: cfg_reg.box_max[2] <= cfg_data;
                REG_TIME_STEP: cfg_reg.time_step  <= cfg_data[TS_W-1:0];
                REG_FRICTION:  cfg_reg.friction   <= cfg_data[MU_W-1:0];
                default: ;
            endcase
        end
    end

    // front: predict and classify
    pwf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    assign push_ready = !fifo_full;

    // queue decouples front from the wall pipelines
    pwf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (pop),
        .full      (fifo_full),
        .empty     (fifo_empty),
        .count     (fifo_count),
        .head      (head)
    );

    // back pipelines move together unless a finished result is held
    assign adv = !m_tvalid || m_tready;
    assign pop = adv && !fifo_empty;

    // x wall: normal x, tangents y, z
    assign w0_in.valid = !fifo_empty;
    assign w0_in.en    = head.hit_mask[0];
    assign w0_in.mask  = head.hit_mask;
    assign w0_in.va    = head.vel_x;
    assign w0_in.vb    = head.vel_y;
    assign w0_in.vc    = head.vel_z;

    pwf_wall u_wall_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .friction (cfg_reg.friction),
        .in_bus   (w0_in),
        .out_bus  (w0_out)
    );

    // y wall: rotate to (y, z, x)
    assign w1_in.valid = w0_out.valid;
    assign w1_in.en    = w0_out.mask[1];
    assign w1_in.mask  = w0_out.mask;
    assign w1_in.va    = w0_out.vb;
    assign w1_in.vb    = w0_out.vc;
    assign w1_in.vc    = w0_out.va;

    pwf_wall u_wall_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .friction (cfg_reg.friction),
        .in_bus   (w1_in),
        .out_bus  (w1_out)
    );

    // z wall: rotate to (z, x, y)
    assign w2_in.valid = w1_out.valid;
    assign w2_in.en    = w1_out.mask[2];
    assign w2_in.mask  = w1_out.mask;
    assign w2_in.va    = w1_out.vb;
    assign w2_in.vb    = w1_out.vc;
    assign w2_in.vc    = w1_out.va;

    pwf_wall u_wall_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .friction (cfg_reg.friction),
        .in_bus   (w2_in),
        .out_bus  (w2_out)
    );

    // last wall stage is the output register; unrotate from (z, x, y)
    assign m_tvalid = w2_out.valid;
    assign m_tdata  = {5'd0, w2_out.mask, w2_out.va, w2_out.vc, w2_out.vb};

    // queue never holds more than its depth
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    // a z wall hit always drops the z velocity
    a_z_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3*VW+2] |-> m_tdata[3*VW-1:2*VW] == '0)
        else $error("z normal velocity not dropped");

    // hits on all three walls leave no velocity
    a_all_walls: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3*VW+2:3*VW] == 3'b111) |-> m_tdata[3*VW-1:0] == '0)
        else $error("velocity left after three wall hits");

endmodule

`default_nettype wire

### sim/tb_particle_wall_friction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_wall_friction: self-checking bench for the wall friction block
// drives particles through the stream input with random gaps, predicts the
// friction velocity and hit mask per particle and compares each result
// transfer in order; box, time step and friction change between phases
// ----------------------------------------------------------------------------

// in-order store of predicted results with mismatch accounting
class wall_friction_board;
    logic [103:0] pending[$];
    int           mismatches;
    int           checked;

    function new();
        mismatches = 0;
        checked    = 0;
    endfunction

    function void note_particle(logic [103:0] predicted);
        pending.insert(pending.size(), predicted);
    endfunction

    function void check_result(logic [103:0] got);
        logic [103:0] want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (want[98:0] !== got[98:0] || got[103:99] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: vx %h/%h vy %h/%h vz %h/%h mask %h/%h (exp/got)",
                         want[31:0], got[31:0], want[63:32], got[63:32],
                         want[95:64], got[95:64], want[98:96], got[98:96]);
        end
    endfunction
endclass

module tb_particle_wall_friction;
    import pwf_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [VW-1:0]     cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;        // new_vel_x, new_vel_y, new_vel_z, hit_mask, pad

    particle_wall_friction DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    wall_friction_board board = new();

    // model copy of the register file
    logic signed [31:0] box_lo[3];
    logic signed [31:0] box_hi[3];
    logic [16:0]        step_q;
    logic [20:0]        mu_q;

    int  cycles = 0;
    bit  calm = 1'b0;      // no idling in the final stretch
    bit  sink_on = 1'b0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("FAIL particle_wall_friction");
            $finish;
        end
    end

    function automatic longint floor_q(longint x);
        return x >>> FRAC_BITS;   // arithmetic shift is a floor
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // friction against one wall, axis a is the normal
    function automatic void wall_slide(ref longint v[3], input int a);
        int b, c;
        longint unsigned vn, mb, mc, vt, lim, s;
        b  = (a + 1) % 3;
        c  = (a + 2) % 3;
        vn = v[a] < 0 ? -v[a] : v[a];
        mb = v[b] < 0 ? -v[b] : v[b];
        mc = v[c] < 0 ? -v[c] : v[c];
        vt = root_floor(mb * mb + mc * mc);
        lim = longint'(mu_q) * vn;
        v[a] = 0;
        if ((vt << FRAC_BITS) <= lim) begin
            v[b] = 0;
            v[c] = 0;
        end else begin
            s = (64'd1 << FRAC_BITS) - lim / vt;
            v[b] = clamp32(floor_q(v[b] * longint'(s)));
            v[c] = clamp32(floor_q(v[c] * longint'(s)));
        end
    endfunction

    function automatic logic [103:0] friction_velocity(logic [IN_W-1:0] d);
        longint v[3];
        longint p;
        logic [2:0] hit = 3'd0;
        logic [103:0] r = '0;
        longint pred[3];
        for (int a = 0; a < 3; a++) begin
            p = longint'($signed(d[32*a +: 32]));
            v[a] = longint'($signed(d[32*(a+3) +: 32]));
            pred[a] = clamp32(p + floor_q(longint'(step_q) * v[a]));
        end
        for (int a = 0; a < 3; a++) begin
            if (pred[a] > box_hi[a] || pred[a] < box_lo[a]) begin
                hit[a] = 1'b1;
                wall_slide(v, a);
            end
        end
        r[31:0]  = v[0][31:0];
        r[63:32] = v[1][31:0];
        r[95:64] = v[2][31:0];
        r[98:96] = hit;
        return r;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_TIME_STEP: step_q = val[16:0];
            REG_FRICTION:  mu_q   = val[20:0];
            REG_BOX_MIN_X, REG_BOX_MIN_Y, REG_BOX_MIN_Z: box_lo[int'(idx)] = val;
            default: box_hi[int'(idx) - 3] = val;
        endcase
    endtask

    task automatic set_box(logic [31:0] lo, logic [31:0] hi, logic [31:0] ts,
                           logic [31:0] mu);
        write_reg(REG_BOX_MIN_X, lo);
        write_reg(REG_BOX_MIN_Y, lo);
        write_reg(REG_BOX_MIN_Z, lo);
        write_reg(REG_BOX_MAX_X, hi);
        write_reg(REG_BOX_MAX_Y, hi);
        write_reg(REG_BOX_MAX_Z, hi);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_FRICTION, mu);
    endtask

    // one particle transfer, with an optional burst of idle cycles first
    task automatic send_particle(logic [IN_W-1:0] d);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_particle(friction_velocity(d));
    endtask

    // receiver: ready stalls in bursts, each transfer goes to the board
    initial begin
        int burst;
        forever begin
            @(posedge aclk);
            if (sink_on && m_tvalid && m_tready) board.check_result(m_tdata);
            if (!sink_on || calm || burst > 0) begin
                if (burst > 0) burst--;
                m_tready <= sink_on && (calm || burst == 0);
            end else if ($urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word(int style);
        case (style)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 262143)) - 131072);
            2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 8388607)) - 4194304);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_particle();
        logic [IN_W-1:0] d;
        for (int k = 0; k < 6; k++) begin
            int st;
            st = $urandom_range(0, 9);
            d[32*k +: 32] = rand_word(st < 2 ? 0 : st < 3 ? 2 : st < 6 ? 1 : 3);
        end
        return d;
    endfunction

    int phases = 0;

    initial begin
        logic [IN_W-1:0] d;
        box_lo = '{0, 0, 0};
        box_hi = '{65536, 65536, 65536};
        step_q = 17'd655;
        mu_q   = 21'd0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        sink_on <= 1'b1;
        @(posedge aclk);

        // directed: defaults, extremes, stick and slide, corner hits
        send_particle({6{32'h0000_8000}});
        send_particle({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h80000000, 32'h7FFFFFFF});
        send_particle({32'h80000000, 32'h80000000, 32'h80000000,
                       32'h0, 32'h0, 32'h0});
        send_particle({96'h0, 32'h0, 32'h0, 32'h0});
        send_particle({32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000});
        drain();
        set_box(32'hFFFF_0000, 32'h0001_0000, 32'd65536, 32'd32768);
        send_particle({32'h0, 32'h0, 32'h0004_0000, 32'h0, 32'h0, 32'h0002_0000});
        send_particle({32'h0001_0000, 32'h0, 32'h0004_0000, 32'h0, 32'h0, 32'h0000_1000});
        send_particle({32'h0, 32'h0, 32'h0008_0000, 32'h0, 32'h0, 32'h0003_0000});
        send_particle({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_particle({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        drain();
        set_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h1FFFF, 32'h1FFFFF);   // inverted box
        send_particle({32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0});
        send_particle({96'h0, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF});
        drain();
        set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);    // never a hit
        send_particle({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        drain();

        // random phases with fresh register settings
        for (phases = 0; phases < 12; phases++) begin
            for (int r = 0; r < 8; r++) begin
                logic [31:0] w;
                if (r < 3) w = rand_word($urandom_range(1, 3));
                else if (r < 6) w = box_lo[r - 3] + $urandom_range(0, 8000000);
                else if (r == 6) w = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 65536);
                else w = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1048576);
                write_reg(reg_idx_t'(r), w);
            end
            if (phases == 11) calm = 1'b1;
            for (int n = 0; n < 128; n++) begin
                d = rand_particle();
                send_particle(d);
            end
            drain();
        end

        $display("covered %0d particles over %0d register settings, stalls on both sides",
                 board.checked, phases + 4);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("PASS particle_wall_friction");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("FAIL particle_wall_friction");
        end
        $finish;
    end
endmodule
